[rtl/aln_pkg.sv]
// aln_pkg: shared types and constants for the accept-language negotiator
// holds the scan mode encoding, register indexes, character codes and reset codes
// no dependencies
package aln_pkg;

  typedef enum logic [7:0] {
    MODE_START  = 8'b0000_0001,
    MODE_SKIP   = 8'b0000_0010,
    MODE_TAG    = 8'b0000_0100,
    MODE_REST   = 8'b0000_1000,
    MODE_QSTART = 8'b0001_0000,
    MODE_INT    = 8'b0010_0000,
    MODE_FRAC   = 8'b0100_0000,
    MODE_DONE   = 8'b1000_0000
  } mode_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TABLE_SIZE = 3'd0,
    REG_CODE_ZERO  = 3'd1,
    REG_CODE_ONE   = 3'd2,
    REG_CODE_TWO   = 3'd3,
    REG_CODE_THREE = 3'd4
  } reg_index_t;

  localparam int WEIGHT_W = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;
  localparam int COUNT_W = 3;
  localparam logic [COUNT_W-1:0] TABLE_SIZE_RESET = 3'd3;
  localparam int CFG_DATA_W = 64;
  localparam int RESET_CODES = 4;
  localparam logic [CFG_DATA_W-1:0] CODE_RESET [RESET_CODES] = '{
    64'd28261, 64'd30066, 64'd29281, 64'd0
  };

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_Q     = 8'h71;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_SEMI = 2'd1;
  localparam logic [1:0] MARK_Q    = 2'd2;

endpackage

[rtl/accept_language_negotiator.sv]
// accept_language_negotiator: picks the best table language for an accept-language header
// one header byte per transaction in, one result transaction per header out
// depends on aln_pkg
//
// usage:
//   s_tdata[7:0] carries header bytes, s_tlast marks the final byte of a header.
//   each byte updates the parse state in the cycle it is accepted; the byte
//   marked last also closes the header and loads the result register.
//   m_tdata carries the result in the cycle after the last byte is accepted.
//   throughput is one byte per cycle while no result is held stalled.
//   the per-byte path is the tag compare against every table entry, the weight
//   digit accumulate and the best-weight compare, all between the state
//   registers and the result register.
//   the cfg channel writes the table size (index 0) and the codes (1 to 4);
//   write only while no header is in flight. cfg_ready is high outside reset.
//   reset returns the table to its defaults and clears the parse state;
//   s_tready and cfg_ready are low during reset.
//   when the receiver stalls with a result held, s_tready drops until the
//   result is taken; a result transaction frees the slot in the same cycle.
module accept_language_negotiator #(
  parameter int NUM_LANGUAGES          = 4,
  parameter int CODE_BYTES             = 8,
  parameter int WEIGHT_FRACTION_DIGITS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // header_byte
  input  logic                                 s_tlast,   // last_byte
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [23:0]                          m_tdata,   // chosen_language, any_match, chosen_weight
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aln_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [aln_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int N      = NUM_LANGUAGES;
  localparam int CB     = CODE_BYTES;
  localparam int WFD    = WEIGHT_FRACTION_DIGITS;
  localparam int TL_W   = $clog2(CB + 2);
  localparam int FD_W   = $clog2(WFD + 1);
  localparam int LANG_W = (N > 1) ? $clog2(N) : 1;
  localparam int CNT_W  = 4;
  localparam int ACC_W  = 21;
  localparam int WW     = aln_pkg::WEIGHT_W;

  function automatic int pow10(int n);
    int r;
    r = 1;
    for (int k = 0; k < n; k++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam int ONE = pow10(WFD);

  typedef logic [N-1:0][CB-1:0][7:0] code_arr_t;
  typedef logic [N-1:0][TL_W-1:0]    len_arr_t;

  typedef struct packed {
    aln_pkg::mode_t     mode;
    logic [TL_W-1:0]    tag_length;
    logic [N-1:0]       prefix_equal;
    logic [N-1:0]       primary_hits;
    logic               primary_seen;
    logic [1:0]         marker_progress;
    logic [WW-1:0]      weight_accum;
    logic [FD_W-1:0]    fraction_digits;
    logic [LANG_W-1:0]  best_language;
    logic [WW-1:0]      best_weight;
    logic               have_best;
  } scan_t;

  function automatic scan_t element_clear(scan_t s);
    scan_t r;
    r = s;
    r.tag_length      = '0;
    r.prefix_equal    = '1;
    r.primary_hits    = '0;
    r.primary_seen    = 1'b0;
    r.marker_progress = aln_pkg::MARK_NONE;
    r.weight_accum    = WW'(ONE);
    r.fraction_digits = '0;
    return r;
  endfunction

  function automatic scan_t header_clear();
    scan_t r;
    r = element_clear('0);
    r.mode          = aln_pkg::MODE_START;
    r.best_language = '0;
    r.best_weight   = '0;
    r.have_best     = 1'b0;
    return r;
  endfunction

  function automatic logic [N-1:0] whole_hits(scan_t s, len_arr_t lens);
    logic [N-1:0] m;
    for (int i = 0; i < N; i++) begin
      m[i] = s.prefix_equal[i] && (lens[i] == s.tag_length);
    end
    return m;
  endfunction

  function automatic scan_t finish(scan_t s, len_arr_t lens, logic [CNT_W-1:0] cnt);
    scan_t             r;
    logic [N-1:0]      full;
    logic [N-1:0]      prim;
    logic              f_found;
    logic              p_found;
    logic [LANG_W-1:0] f_idx;
    logic [LANG_W-1:0] p_idx;
    r       = s;
    full    = whole_hits(s, lens);
    prim    = s.primary_seen ? s.primary_hits : full;
    f_found = 1'b0;
    p_found = 1'b0;
    f_idx   = '0;
    p_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (full[i] && (CNT_W'(i) < cnt)) begin
        f_found = 1'b1;
        f_idx   = LANG_W'(i);
      end
      if (prim[i] && (CNT_W'(i) < cnt)) begin
        p_found = 1'b1;
        p_idx   = LANG_W'(i);
      end
    end
    if ((f_found || p_found) && (!s.have_best || s.weight_accum > s.best_weight)) begin
      r.best_language = f_found ? f_idx : p_idx;
      r.best_weight   = s.weight_accum;
      r.have_best     = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_t tag_byte(scan_t s, logic [7:0] b, code_arr_t codes,
                                     len_arr_t lens);
    scan_t      r;
    logic [7:0] cb;
    r = s;
    if ((b == aln_pkg::CH_MINUS || b == aln_pkg::CH_UNDER) && !s.primary_seen) begin
      r.primary_hits = whole_hits(s, lens);
      r.primary_seen = 1'b1;
    end
    if (s.tag_length < TL_W'(CB)) begin
      for (int i = 0; i < N; i++) begin
        cb = '0;
        for (int p = 0; p < CB; p++) begin
          if (s.tag_length == TL_W'(p)) begin
            cb = codes[i][p];
          end
        end
        if (cb != b) begin
          r.prefix_equal[i] = 1'b0;
        end
      end
      r.tag_length = s.tag_length + 1'b1;
    end else begin
      r.prefix_equal = '0;
      r.tag_length   = TL_W'(CB + 1);
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= aln_pkg::CH_ZERO) && (b <= aln_pkg::CH_NINE);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == aln_pkg::CH_SPACE) || ((b >= aln_pkg::CH_TAB) && (b <= aln_pkg::CH_CR));
  endfunction

  function automatic scan_t feed(scan_t s, logic [7:0] b, code_arr_t codes, len_arr_t lens,
                                 logic [CNT_W-1:0] cnt);
    scan_t            r;
    logic             stop;
    logic [ACC_W-1:0] d;
    logic [ACC_W-1:0] v;
    logic [ACC_W-1:0] place;
    r     = s;
    stop  = 1'b0;
    d     = ACC_W'(b - aln_pkg::CH_ZERO);
    v     = '0;
    place = '0;
    if (r.mode == aln_pkg::MODE_DONE) begin
      stop = 1'b1;
    end
    if (!stop && r.mode == aln_pkg::MODE_START) begin
      if (b == aln_pkg::CH_NUL) begin
        r.mode = aln_pkg::MODE_DONE;
        stop   = 1'b1;
      end else begin
        r.mode = aln_pkg::MODE_SKIP;
      end
    end
    if (!stop && r.mode == aln_pkg::MODE_SKIP) begin
      if (b == aln_pkg::CH_SPACE || b == aln_pkg::CH_COMMA) begin
        stop = 1'b1;
      end else if (b != aln_pkg::CH_NUL) begin
        r.mode = aln_pkg::MODE_TAG;
      end
    end
    if (!stop && b == aln_pkg::CH_NUL) begin
      r      = finish(r, lens, cnt);
      r.mode = aln_pkg::MODE_DONE;
      stop   = 1'b1;
    end
    if (!stop && b == aln_pkg::CH_COMMA) begin
      r      = element_clear(finish(r, lens, cnt));
      r.mode = aln_pkg::MODE_SKIP;
      stop   = 1'b1;
    end
    if (!stop && r.mode == aln_pkg::MODE_TAG) begin
      if (b != aln_pkg::CH_SEMI && b != aln_pkg::CH_SPACE) begin
        r    = tag_byte(r, b, codes, lens);
        stop = 1'b1;
      end else begin
        r.mode = aln_pkg::MODE_REST;
      end
    end
    if (!stop && r.mode == aln_pkg::MODE_QSTART) begin
      if (is_space(b)) begin
        stop = 1'b1;
      end else if (b == aln_pkg::CH_DOT) begin
        r.mode = aln_pkg::MODE_FRAC;
        stop   = 1'b1;
      end else if (b == aln_pkg::CH_PLUS) begin
        r.mode = aln_pkg::MODE_INT;
        stop   = 1'b1;
      end else if (b == aln_pkg::CH_MINUS) begin
        r.mode = aln_pkg::MODE_REST;
        stop   = 1'b1;
      end else begin
        r.mode = is_digit(b) ? aln_pkg::MODE_INT : aln_pkg::MODE_REST;
      end
    end
    if (!stop && r.mode == aln_pkg::MODE_INT) begin
      if (is_digit(b)) begin
        v = (ACC_W'(r.weight_accum) << 3) + (ACC_W'(r.weight_accum) << 1)
          + d * ACC_W'(ONE);
        r.weight_accum = (v > ACC_W'(aln_pkg::WEIGHT_MAX)) ? aln_pkg::WEIGHT_MAX
                                                           : v[WW-1:0];
        stop = 1'b1;
      end else if (b == aln_pkg::CH_DOT) begin
        r.mode = aln_pkg::MODE_FRAC;
        stop   = 1'b1;
      end else begin
        r.mode = aln_pkg::MODE_REST;
      end
    end
    if (!stop && r.mode == aln_pkg::MODE_FRAC) begin
      if (is_digit(b)) begin
        if (r.fraction_digits < FD_W'(WFD)) begin
          for (int k = 0; k < WFD; k++) begin
            if (r.fraction_digits == FD_W'(k)) begin
              place = ACC_W'(pow10(WFD - 1 - k));
            end
          end
          v = ACC_W'(r.weight_accum) + d * place;
          r.weight_accum = (v > ACC_W'(aln_pkg::WEIGHT_MAX)) ? aln_pkg::WEIGHT_MAX
                                                             : v[WW-1:0];
          r.fraction_digits = r.fraction_digits + 1'b1;
        end
        stop = 1'b1;
      end else begin
        r.mode = aln_pkg::MODE_REST;
      end
    end
    if (!stop) begin
      if (b == aln_pkg::CH_SEMI) begin
        r.marker_progress = aln_pkg::MARK_SEMI;
      end else if (b == aln_pkg::CH_Q && r.marker_progress == aln_pkg::MARK_SEMI) begin
        r.marker_progress = aln_pkg::MARK_Q;
      end else if (b == aln_pkg::CH_EQUAL && r.marker_progress == aln_pkg::MARK_Q) begin
        r.marker_progress = aln_pkg::MARK_NONE;
        r.weight_accum    = '0;
        r.fraction_digits = '0;
        r.mode            = aln_pkg::MODE_QSTART;
      end else begin
        r.marker_progress = aln_pkg::MARK_NONE;
      end
    end
    return r;
  endfunction

  logic [aln_pkg::COUNT_W-1:0] table_size;
  code_arr_t                   codes;
  len_arr_t                    code_len;
  logic [CNT_W-1:0]            count_eff;
  scan_t                       st;
  scan_t                       st_byte;
  scan_t                       st_end;
  logic                        in_fire;

  assign s_tready  = !rst && (!m_tvalid || m_tready);
  assign cfg_ready = !rst;
  assign in_fire   = s_tvalid && s_tready;

  // table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= aln_pkg::TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index == aln_pkg::REG_TABLE_SIZE) begin
      table_size <= cfg_data[aln_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (rst) begin
        if (i < aln_pkg::RESET_CODES) begin
          codes[i] <= (CB * 8)'(aln_pkg::CODE_RESET[i % aln_pkg::RESET_CODES]);
        end else begin
          codes[i] <= '0;
        end
      end else if (cfg_valid && cfg_ready && i < aln_pkg::RESET_CODES &&
                   cfg_index == aln_pkg::CFG_INDEX_W'(i + 1)) begin
        codes[i] <= cfg_data[CB*8-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      code_len[i] = TL_W'(CB);
      for (int p = CB - 1; p >= 0; p--) begin
        if (codes[i][p] == aln_pkg::CH_NUL) begin
          code_len[i] = TL_W'(p);
        end
      end
    end
    count_eff = (CNT_W'(table_size) > CNT_W'(N)) ? CNT_W'(N) : CNT_W'(table_size);
  end

  always_comb begin
    st_byte = feed(st, s_tdata, codes, code_len, count_eff);
    st_end  = feed(st_byte, aln_pkg::CH_NUL, codes, code_len, count_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= header_clear();
    end else if (in_fire) begin
      st <= s_tlast ? header_clear() : st_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_tlast) begin
      m_tdata <= {5'd0,
                  st_end.have_best ? st_end.best_weight : WW'(0),
                  st_end.have_best,
                  2'(st_end.best_language)};
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> m_tvalid)
    else $error("result missing after last byte");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_fire && s_tlast))
    else $error("result without a last byte");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[18:3] == '0 && m_tdata[1:0] == '0))
    else $error("unmatched result carries data");

  a_header_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> (st.mode == aln_pkg::MODE_START && !st.have_best))
    else $error("parse state not cleared after header");

endmodule

[tb/accept_language_negotiator_tb.sv]
// accept_language_negotiator_tb: self-checking testbench for the accept-language negotiator
// drives header bytes and table writes, predicts each result and compares it field by field
// depends on aln_pkg and accept_language_negotiator
`timescale 1ns / 100ps

module accept_language_negotiator_tb;

  localparam int NUM_LANG     = 4;
  localparam int CODE_BYTES   = 8;
  localparam int FRAC_DIGITS  = 3;
  localparam int unsigned WEIGHT_ONE = 1000;
  localparam int TOTAL_ITEMS  = 1350;
  localparam int PHASE_ITEMS  = 110;
  localparam logic [aln_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [7:0] NUL_MARK = "#";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_Z     = "z";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [2:0] COUNT_SWEEP [8] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6};

  typedef struct packed {
    logic [1:0]  lang;
    logic        matched;
    logic [15:0] weight;
  } lang_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata = '0;   // header_byte
  logic                            s_tlast = 1'b0; // last_byte
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [23:0]                     m_tdata;        // chosen_language, any_match, chosen_weight
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [aln_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [aln_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  accept_language_negotiator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // negotiation model state
  logic [2:0]     lang_count;
  logic [63:0]    lang_code [NUM_LANG];
  aln_pkg::mode_t scan;
  int unsigned    tag_len;
  logic [3:0]     prefix_eq;
  logic [3:0]     primary_hits;
  logic           primary_seen;
  logic [1:0]     mark;
  int unsigned    w_acc;
  int unsigned    frac_cnt;
  logic [1:0]     best_lang;
  int unsigned    best_w;
  logic           have_best;

  lang_result_t pending_results [$];
  logic [7:0]   hdr_build [$];
  string        dir_text [$];
  bit           dir_typed [$];
  lang_result_t dir_want [$];
  int           sent_bytes = 0;
  int           errors = 0;
  bit           calm = 1'b0;

  function automatic int unsigned code_len(int i);
    for (int n = 0; n < CODE_BYTES; n++)
      if (lang_code[i][8*n +: 8] == aln_pkg::CH_NUL) return n;
    return CODE_BYTES;
  endfunction

  function automatic logic [3:0] whole_match();
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < NUM_LANG; i++)
      if (prefix_eq[i] && code_len(i) == tag_len) m[i] = 1'b1;
    return m;
  endfunction

  function automatic void clear_element();
    tag_len = 0;
    prefix_eq = '1;
    primary_hits = '0;
    primary_seen = 1'b0;
    mark = aln_pkg::MARK_NONE;
    w_acc = WEIGHT_ONE;
    frac_cnt = 0;
  endfunction

  function automatic void clear_header();
    clear_element();
    scan = aln_pkg::MODE_START;
    best_lang = '0;
    best_w = 0;
    have_best = 1'b0;
  endfunction

  function automatic int first_hit(logic [3:0] mask, int unsigned n);
    for (int i = 0; i < n; i++)
      if (mask[i]) return i;
    return -1;
  endfunction

  function automatic void close_element();
    int unsigned n;
    logic [3:0]  full;
    logic [3:0]  prim;
    int          hit;
    n = (lang_count > NUM_LANG) ? NUM_LANG : lang_count;
    full = whole_match();
    prim = primary_seen ? primary_hits : full;
    hit = first_hit(full, n);
    if (hit < 0) hit = first_hit(prim, n);
    if (hit >= 0 && (!have_best || w_acc > best_w)) begin
      best_lang = hit[1:0];
      best_w = w_acc;
      have_best = 1'b1;
    end
  endfunction

  function automatic void tag_step(logic [7:0] b);
    if ((b == aln_pkg::CH_MINUS || b == aln_pkg::CH_UNDER) && !primary_seen) begin
      primary_hits = whole_match();
      primary_seen = 1'b1;
    end
    if (tag_len < CODE_BYTES) begin
      for (int i = 0; i < NUM_LANG; i++)
        if (lang_code[i][8*tag_len +: 8] != b) prefix_eq[i] = 1'b0;
      tag_len++;
    end else begin
      prefix_eq = '0;
      tag_len = CODE_BYTES + 1;
    end
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= aln_pkg::CH_ZERO && b <= aln_pkg::CH_NINE;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == aln_pkg::CH_SPACE || (b >= aln_pkg::CH_TAB && b <= aln_pkg::CH_CR);
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    int unsigned v;
    int unsigned place;
    if (scan == aln_pkg::MODE_DONE) return;
    if (scan == aln_pkg::MODE_START) begin
      if (b == aln_pkg::CH_NUL) begin
        scan = aln_pkg::MODE_DONE;
        return;
      end
      scan = aln_pkg::MODE_SKIP;
    end
    if (scan == aln_pkg::MODE_SKIP) begin
      if (b == aln_pkg::CH_SPACE || b == aln_pkg::CH_COMMA) return;
      if (b == aln_pkg::CH_NUL) begin
        close_element();
        scan = aln_pkg::MODE_DONE;
        return;
      end
      scan = aln_pkg::MODE_TAG;
    end
    if (b == aln_pkg::CH_NUL) begin
      close_element();
      scan = aln_pkg::MODE_DONE;
      return;
    end
    if (b == aln_pkg::CH_COMMA) begin
      close_element();
      clear_element();
      scan = aln_pkg::MODE_SKIP;
      return;
    end
    if (scan == aln_pkg::MODE_TAG) begin
      if (b != aln_pkg::CH_SEMI && b != aln_pkg::CH_SPACE) begin
        tag_step(b);
        return;
      end
      scan = aln_pkg::MODE_REST;
    end
    if (scan == aln_pkg::MODE_QSTART) begin
      if (is_blank(b)) return;
      if (b == aln_pkg::CH_DOT) begin
        scan = aln_pkg::MODE_FRAC;
        return;
      end
      if (b == aln_pkg::CH_PLUS) begin
        scan = aln_pkg::MODE_INT;
        return;
      end
      if (b == aln_pkg::CH_MINUS) begin
        scan = aln_pkg::MODE_REST;
        return;
      end
      scan = is_digit(b) ? aln_pkg::MODE_INT : aln_pkg::MODE_REST;
    end
    if (scan == aln_pkg::MODE_INT) begin
      if (is_digit(b)) begin
        v = w_acc * 10 + 32'(b - aln_pkg::CH_ZERO) * WEIGHT_ONE;
        w_acc = (v > 32'(aln_pkg::WEIGHT_MAX)) ? 32'(aln_pkg::WEIGHT_MAX) : v;
        return;
      end
      if (b == aln_pkg::CH_DOT) begin
        scan = aln_pkg::MODE_FRAC;
        return;
      end
      scan = aln_pkg::MODE_REST;
    end
    if (scan == aln_pkg::MODE_FRAC) begin
      if (is_digit(b)) begin
        if (frac_cnt < FRAC_DIGITS) begin
          place = WEIGHT_ONE;
          for (int k = 0; k <= frac_cnt; k++) place = place / 10;
          w_acc = w_acc + 32'(b - aln_pkg::CH_ZERO) * place;
          if (w_acc > 32'(aln_pkg::WEIGHT_MAX)) w_acc = 32'(aln_pkg::WEIGHT_MAX);
          frac_cnt++;
        end
        return;
      end
      scan = aln_pkg::MODE_REST;
    end
    // looking for the q weight marker
    if (b == aln_pkg::CH_SEMI) begin
      mark = aln_pkg::MARK_SEMI;
    end else if (b == aln_pkg::CH_Q && mark == aln_pkg::MARK_SEMI) begin
      mark = aln_pkg::MARK_Q;
    end else if (b == aln_pkg::CH_EQUAL && mark == aln_pkg::MARK_Q) begin
      mark = aln_pkg::MARK_NONE;
      w_acc = 0;
      frac_cnt = 0;
      scan = aln_pkg::MODE_QSTART;
    end else begin
      mark = aln_pkg::MARK_NONE;
    end
  endfunction

  function automatic bit take_byte(input logic [7:0] b, input logic last,
                                   output lang_result_t r);
    sent_bytes++;
    feed_byte(b);
    r = '0;
    if (!last) return 1'b0;
    feed_byte(aln_pkg::CH_NUL);
    r.lang = best_lang;
    r.matched = have_best;
    r.weight = have_best ? best_w[15:0] : '0;
    clear_header();
    return 1'b1;
  endfunction

  function automatic void set_register(logic [aln_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    if (idx == aln_pkg::REG_TABLE_SIZE) lang_count = val[2:0];
    else if (idx >= aln_pkg::REG_CODE_ZERO && idx <= aln_pkg::REG_CODE_THREE)
      lang_code[idx - 1] = val;
  endfunction

  // header text builders
  function automatic void add_byte(logic [7:0] b);
    hdr_build.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_digit();
    add_byte(aln_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_letter();
    add_byte(8'($urandom_range(CH_A, CH_Z)));
  endfunction

  function automatic void add_weight();
    int unsigned n_int;
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) add_byte(aln_pkg::CH_SPACE);
      else add_byte(8'($urandom_range(aln_pkg::CH_TAB, aln_pkg::CH_CR)));
    end
    case ($urandom_range(0, 19))
      0:       add_byte(aln_pkg::CH_MINUS);
      1, 2:    add_byte(aln_pkg::CH_PLUS);
      default: ;
    endcase
    n_int = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(0, 1);
    repeat (n_int) add_digit();
    if ($urandom_range(0, 2) != 0) begin
      add_byte(aln_pkg::CH_DOT);
      repeat ($urandom_range(0, 5)) add_digit();
    end
  endfunction

  function automatic void add_element();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 9);
    if (pick == 1) begin
      add_byte(CH_STAR);
    end else if (pick == 2) begin
      repeat ($urandom_range(1, 10)) add_letter();
    end else if (pick > 2) begin
      idx = $urandom_range(0, NUM_LANG - 1);
      for (int k = 0; k < CODE_BYTES && lang_code[idx][8*k +: 8] != aln_pkg::CH_NUL; k++)
        add_byte(lang_code[idx][8*k +: 8]);
      if ($urandom_range(0, 2) == 0) begin
        add_byte($urandom_range(0, 1) ? aln_pkg::CH_MINUS : aln_pkg::CH_UNDER);
        repeat ($urandom_range(1, 3)) add_letter();
      end
    end
    if ($urandom_range(0, 3) == 0) add_byte(aln_pkg::CH_SPACE);
    if ($urandom_range(0, 5) == 0) add_text(";level=1");
    if ($urandom_range(0, 2) != 0) begin
      add_text(";q=");
      add_weight();
    end
  endfunction

  function automatic void build_header();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    hdr_build.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
    end else begin
      for (int e = $urandom_range(1, 4); e > 0; e--) begin
        add_element();
        if (e > 1) begin
          case ($urandom_range(0, 3))
            0:       add_text(",");
            1:       add_text(", ");
            2:       add_text(" ,");
            default: add_text(",,");
          endcase
        end
      end
      if (kind == 1)
        repeat ($urandom_range(1, 2))
          hdr_build.insert($urandom_range(0, hdr_build.size()), 8'($urandom));
    end
    case ($urandom_range(0, 11))
      0: add_byte(aln_pkg::CH_NUL);
      1: begin
        add_byte(aln_pkg::CH_NUL);
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
      default: ;
    endcase
    if (hdr_build.size() == 0) add_byte(aln_pkg::CH_NUL);
  endfunction

  function automatic logic [63:0] random_code();
    logic [63:0] c;
    int unsigned n;
    c = '0;
    case ($urandom_range(0, 9))
      0: c = '0;
      1: c = '1;
      2: c = {$urandom, $urandom};
      3: for (int i = 0; i < CODE_BYTES; i++) c[8*i +: 8] = 8'($urandom_range(1, 255));
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) c[8*i +: 8] = 8'($urandom_range(CH_A, CH_Z));
      end
    endcase
    return c;
  endfunction

  function automatic void dir_row(string text, bit typed, logic [1:0] lang, logic matched,
                                  logic [15:0] weight);
    dir_text.push_back(text);
    dir_typed.push_back(typed);
    dir_want.push_back(lang_result_t'{lang, matched, weight});
  endfunction

  task automatic send_header(input logic [7:0] text [$], input bit typed,
                             input lang_result_t want);
    lang_result_t r;
    for (int i = 0; i < text.size(); i++) begin
      while (!calm && $urandom_range(0, 99) < 24) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text[i];
      s_tlast  <= (i == text.size() - 1);
      do @(posedge clk); while (!s_tready);
      if (take_byte(text[i], i == text.size() - 1, r))
        pending_results.push_back(typed ? want : r);
    end
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aln_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    set_register(idx, val);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // result side
  initial begin
    lang_result_t want;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result transaction with no header pending: %h", m_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("chosen_language", 16'(want.lang), 16'(m_tdata[1:0]));
          check_field("any_match", 16'(want.matched), 16'(m_tdata[2]));
          check_field("chosen_weight", want.weight, m_tdata[18:3]);
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase_end;
    int phase;
    lang_count = aln_pkg::TABLE_SIZE_RESET;
    for (int i = 0; i < NUM_LANG; i++) lang_code[i] = aln_pkg::CODE_RESET[i];
    clear_header();

    // reset table: en, ru, ar, empty; three entries in use; '#' stands for a zero byte
    dir_row("#",                                       1, 2'd0, 1'b0, 16'd0);
    dir_row("en",                                      1, 2'd0, 1'b1, 16'd1000);
    dir_row("ru;q=0.5",                                1, 2'd1, 1'b1, 16'd500);
    dir_row("fr",                                      1, 2'd0, 1'b0, 16'd0);
    dir_row("de, ar;q=0.9, ru;q=0.9",                  1, 2'd2, 1'b1, 16'd900);
    dir_row("en-US;q=0.1,ru_RU;q=0.2",                 1, 2'd1, 1'b1, 16'd200);
    dir_row("ar;q=99999",                              1, 2'd2, 1'b1, 16'd65535);
    dir_row("ru;q=-1",                                 1, 2'd1, 1'b1, 16'd0);
    dir_row("ar;q=",                                   1, 2'd2, 1'b1, 16'd0);
    dir_row("en;q=0.12345",                            1, 2'd0, 1'b1, 16'd123);
    dir_row("ru#en;q=2",                               1, 2'd1, 1'b1, 16'd1000);
    dir_row("ru;q=1e3",                                0, 2'd0, 1'b0, 16'd0);
    dir_row("ar;q=0.5;q=0.7",                          0, 2'd0, 1'b0, 16'd0);
    dir_row(" , ,ru ;q=\t+.25",                        0, 2'd0, 1'b0, 16'd0);
    dir_row("ru,,",                                    0, 2'd0, 1'b0, 16'd0);
    dir_row("abcdefghij;q=1",                          0, 2'd0, 1'b0, 16'd0);
    dir_row("*;q=0.5, en-gb-oxendict;q=0.8, ru;q=0.8", 0, 2'd0, 1'b0, 16'd0);
    dir_row("EN, ru;q=.3\015",                         0, 2'd0, 1'b0, 16'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < dir_text.size(); r++) begin
      hdr_build.delete();
      for (int i = 0; i < dir_text[r].len(); i++)
        add_byte((dir_text[r][i] == NUL_MARK) ? aln_pkg::CH_NUL : dir_text[r][i]);
      send_header(hdr_build, dir_typed[r], dir_want[r]);
    end

    phase = 0;
    while (sent_bytes < TOTAL_ITEMS) begin
      settle();
      write_reg(aln_pkg::REG_TABLE_SIZE,
                64'(phase < 8 ? COUNT_SWEEP[phase] : 3'($urandom_range(0, 7))));
      write_reg(aln_pkg::REG_CODE_ZERO, random_code());
      write_reg(aln_pkg::REG_CODE_ONE, random_code());
      write_reg(aln_pkg::REG_CODE_TWO, random_code());
      write_reg(aln_pkg::REG_CODE_THREE, random_code());
      if (phase % 3 == 1) write_reg(REG_UNUSED, {$urandom, $urandom});
      cfg_valid <= 1'b0;
      calm = (phase % 4 == 2);
      phase_end = sent_bytes + PHASE_ITEMS;
      if (phase_end > TOTAL_ITEMS) phase_end = TOTAL_ITEMS;
      while (sent_bytes < phase_end) begin
        build_header();
        send_header(hdr_build, 1'b0, '0);
      end
      phase++;
    end
    calm = 1'b0;
    settle();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
